[rtl/core/assert_macros.svh]
// shared assertion macros for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked on clk, off while in reset
`define TRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked on clk, also checked during reset
`define TRP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/trp_pkg.sv]
package trp_pkg;

  localparam int TIME_BITS   = 32;
  localparam int WINDOW_BITS = 20;
  localparam int REG_BITS    = 20;
  localparam int LEVEL_BITS  = 16;
  localparam int DUTY_BITS   = 14;
  localparam int CMD_BITS    = 2;
  localparam int CFG_IDX_BITS = 2;
  // room for (window_count + 1) * full scale and duty * window
  localparam int PROD_BITS   = WINDOW_BITS + 1 + DUTY_BITS;

  localparam logic [DUTY_BITS-1:0]   FULL_SCALE   = 14'd10000;
  localparam logic [REG_BITS-1:0]    WINDOW_RESET = 20'd10000;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_TICK      = 2'd0,
    CMD_SET_LEVEL = 2'd1,
    CMD_FORCE_OFF = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_WINDOW  = 2'd0,
    REG_MIN_ON  = 2'd1,
    REG_MIN_OFF = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [CMD_BITS-1:0]          cmd;
    logic signed [LEVEL_BITS-1:0] level;
  } item_t;

  typedef struct packed {
    logic [REG_BITS-1:0] window;
    logic [REG_BITS-1:0] min_on;
    logic [REG_BITS-1:0] min_off;
  } cfg_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

endpackage

[rtl/core/trp_in_if.sv]
interface trp_in_if;
  logic                                     valid;
  logic                                     ready;
  logic [trp_pkg::CMD_BITS-1:0]             cmd;
  logic signed [trp_pkg::LEVEL_BITS-1:0]    level;

  modport source (output valid, output cmd, output level, input ready);
  modport sink   (input valid, input cmd, input level, output ready);
endinterface

[rtl/core/trp_out_if.sv]
interface trp_out_if;
  logic valid;
  logic ready;
  logic relay_on;
  logic relay_changed;

  modport source (output valid, output relay_on, output relay_changed, input ready);
  modport sink   (input valid, input relay_on, input relay_changed, output ready);
endinterface

[rtl/core/trp_cfg_regs.sv]
module trp_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [trp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [trp_pkg::REG_BITS-1:0]      cfg_wdata,
  output trp_pkg::cfg_t                     cfg
);

  trp_pkg::cfg_t cfg_r;
  trp_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        trp_pkg::REG_WINDOW:  cfg_nxt.window  = cfg_wdata;
        trp_pkg::REG_MIN_ON:  cfg_nxt.min_on  = cfg_wdata;
        trp_pkg::REG_MIN_OFF: cfg_nxt.min_off = cfg_wdata;
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window  <= trp_pkg::WINDOW_RESET;
      cfg_r.min_on  <= '0;
      cfg_r.min_off <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/core/trp_in_stage.sv]
module trp_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  trp_in_if.sink         in_ch,
  input  logic           take,
  output trp_pkg::stage_t stage
);

  logic           valid_r;
  logic           valid_nxt;
  trp_pkg::item_t item_r;
  logic           accept;

  assign in_ch.ready = !valid_r || take;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.cmd   <= in_ch.cmd;
      item_r.level <= in_ch.level;
    end
  end

  assign stage.valid = valid_r;
  assign stage.item  = item_r;

endmodule

[rtl/core/trp_engine.sv]
module trp_engine (
  input  logic            clk,
  input  logic            rst_n,
  input  trp_pkg::cfg_t   cfg,
  input  trp_pkg::stage_t stage,
  output logic            take,
  trp_out_if.source       out_ch
);

  logic [trp_pkg::WINDOW_BITS-1:0] wc_r, wc_nxt;
  logic [trp_pkg::DUTY_BITS-1:0]   duty_r, duty_nxt;
  logic                            relay_r, relay_nxt;
  logic [trp_pkg::TIME_BITS-1:0]   tick_r, tick_nxt;
  logic [trp_pkg::TIME_BITS-1:0]   last_r, last_nxt;
  logic                            out_v_r, out_v_nxt;
  logic                            out_on_r;
  logic                            out_chg_r;
  logic                            changed;

  logic [trp_pkg::WINDOW_BITS-1:0] win_eff;
  logic [trp_pkg::WINDOW_BITS-1:0] wc_inc;
  logic [trp_pkg::WINDOW_BITS-1:0] wc_tick;
  logic [trp_pkg::WINDOW_BITS:0]   wc_plus1;
  logic [trp_pkg::PROD_BITS-1:0]   scaled_pos;
  logic [trp_pkg::PROD_BITS-1:0]   on_prod;
  logic                            want;
  logic [trp_pkg::TIME_BITS-1:0]   tick_inc;
  logic [trp_pkg::TIME_BITS-1:0]   since;
  logic [trp_pkg::REG_BITS-1:0]    guard;
  logic                            guard_done;
  logic [trp_pkg::DUTY_BITS-1:0]   level_clamped;

  assign take = stage.valid && (!out_v_r || out_ch.ready);

  // window counter and on-time test, without a divider
  assign win_eff  = (cfg.window[trp_pkg::WINDOW_BITS-1:0] == '0)
                    ? trp_pkg::WINDOW_BITS'(trp_pkg::FULL_SCALE)
                    : cfg.window[trp_pkg::WINDOW_BITS-1:0];
  assign wc_inc   = wc_r + 1'b1;
  assign wc_tick  = (wc_inc >= win_eff) ? '0 : wc_inc;
  assign wc_plus1 = {1'b0, wc_tick} + 1'b1;
  assign scaled_pos = trp_pkg::PROD_BITS'(wc_plus1)
                      * trp_pkg::PROD_BITS'(trp_pkg::FULL_SCALE);
  assign on_prod    = trp_pkg::PROD_BITS'(duty_r) * trp_pkg::PROD_BITS'(win_eff);
  assign want       = scaled_pos <= on_prod;

  // guard time since last switch, modulo the tick counter width
  assign tick_inc   = tick_r + 1'b1;
  assign since      = tick_inc - last_r;
  assign guard      = relay_r ? cfg.min_on : cfg.min_off;
  assign guard_done = since >= trp_pkg::TIME_BITS'(guard);

  always_comb begin
    if (stage.item.level[trp_pkg::LEVEL_BITS-1]) begin
      level_clamped = '0;
    end else if (stage.item.level[trp_pkg::LEVEL_BITS-2:0]
                 > (trp_pkg::LEVEL_BITS-1)'(trp_pkg::FULL_SCALE)) begin
      level_clamped = trp_pkg::FULL_SCALE;
    end else begin
      level_clamped = stage.item.level[trp_pkg::DUTY_BITS-1:0];
    end
  end

  always_comb begin
    wc_nxt    = wc_r;
    duty_nxt  = duty_r;
    relay_nxt = relay_r;
    tick_nxt  = tick_r;
    last_nxt  = last_r;
    changed   = 1'b0;
    if (take) begin
      case (stage.item.cmd)
        trp_pkg::CMD_TICK: begin
          tick_nxt = tick_inc;
          wc_nxt   = wc_tick;
          if ((want != relay_r) && guard_done) begin
            relay_nxt = want;
            last_nxt  = tick_inc;
            changed   = 1'b1;
          end
        end
        trp_pkg::CMD_SET_LEVEL: begin
          duty_nxt = level_clamped;
        end
        trp_pkg::CMD_FORCE_OFF: begin
          changed   = relay_r;
          duty_nxt  = '0;
          relay_nxt = 1'b0;
          last_nxt  = tick_r;
        end
        default: begin
          changed = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (take) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_r    <= '0;
      duty_r  <= '0;
      relay_r <= 1'b0;
      tick_r  <= '0;
      last_r  <= '0;
      out_v_r <= 1'b0;
    end else begin
      wc_r    <= wc_nxt;
      duty_r  <= duty_nxt;
      relay_r <= relay_nxt;
      tick_r  <= tick_nxt;
      last_r  <= last_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_on_r  <= relay_nxt;
      out_chg_r <= changed;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.relay_on      = out_on_r;
  assign out_ch.relay_changed = out_chg_r;

endmodule

[rtl/core/time_proportioning_relay.sv]
// Slow PWM relay driver with minimum on and off times. Each item is a command
// (one 1 ms tick, set duty level, force off) and gives exactly one result: the
// relay state after the item and whether the item switched it. Items pass an
// input register, then combinational logic (window counter, one 14 x 20 bit
// product against the scaled window position, guard time compare) into the
// result register: one item per cycle while the output is not stalled, and a new
// item is taken while a finished result still waits to be taken.
// Configuration writes take effect at the next clock and belong in idle time.
// All state is ready straight out of reset.
module time_proportioning_relay (
  input  logic                              clk,
  input  logic                              rst_n,
  trp_in_if.sink                            in_ch,
  trp_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [trp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [trp_pkg::REG_BITS-1:0]      cfg_wdata
);

  trp_pkg::cfg_t   cfg;
  trp_pkg::stage_t stage;
  logic            take;

  trp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  trp_in_stage u_in (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .take  (take),
    .stage (stage)
  );

  trp_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .stage  (stage),
    .take   (take),
    .out_ch (out_ch)
  );

endmodule

[rtl/core/trp_checker.sv]
`include "assert_macros.svh"

module trp_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic relay_on,
  input logic relay_changed
);

  logic last_on_r;
  logic last_on_nxt;
  logic out_take;

  assign out_take    = out_valid && out_ready;
  assign last_on_nxt = out_take ? relay_on : last_on_r;

  // relay state as shown by the previous item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_on_r <= 1'b0;
    end else begin
      last_on_r <= last_on_nxt;
    end
  end

  `TRP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `TRP_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(relay_on) && $stable(relay_changed), "stalled result changed")
  `TRP_ASSERT(a_changed_match, out_take |-> (relay_changed == (relay_on != last_on_r)), "relay_changed disagrees with relay state")
  `TRP_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "input stalled with empty output")
  `TRP_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result shown after reset")

endmodule

bind time_proportioning_relay trp_checker u_trp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .relay_on      (out_ch.relay_on),
  .relay_changed (out_ch.relay_changed)
);

[tb/relay_checker.sv]
`timescale 1ns / 1ps
module relay_checker
  import trp_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [CMD_BITS-1:0]          in_cmd,
  input  logic signed [LEVEL_BITS-1:0] in_level,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic                         out_relay_on,
  input  logic                         out_relay_changed,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [REG_BITS-1:0]          cfg_wdata,
  output int                           fail_total,
  output int                           pending
);

  typedef struct packed {
    logic relay_on;
    logic changed;
  } relay_result_t;

  logic [REG_BITS-1:0]    window_len;
  logic [REG_BITS-1:0]    min_on_len;
  logic [REG_BITS-1:0]    min_off_len;
  logic [WINDOW_BITS-1:0] win_pos;
  logic [DUTY_BITS-1:0]   duty;
  logic                   relay_q;
  logic [TIME_BITS-1:0]   tick_count;
  logic [TIME_BITS-1:0]   last_switch;

  relay_result_t expected_relay_q[$];
  int mismatches = 0;

  function automatic relay_result_t apply_command(input logic [CMD_BITS-1:0] cmd,
                                                  input logic [LEVEL_BITS-1:0] level);
    relay_result_t res;
    logic [63:0] span;
    logic [63:0] on_time;
    logic [TIME_BITS-1:0] since;
    logic [REG_BITS-1:0] guard;
    logic want;
    res.changed = 1'b0;
    case (cmd_t'(cmd))
      CMD_TICK: begin
        span = (window_len == '0) ? 64'(FULL_SCALE) : 64'(window_len);
        tick_count = tick_count + 1'b1;
        win_pos = win_pos + 1'b1;
        if (64'(win_pos) >= span) begin
          win_pos = '0;
        end
        on_time = (64'(duty) * span) / 64'(FULL_SCALE);
        want = (64'(win_pos) < on_time);
        if (want != relay_q) begin
          guard = relay_q ? min_on_len : min_off_len;
          since = tick_count - last_switch;
          if (since >= TIME_BITS'(guard)) begin
            relay_q = want;
            last_switch = tick_count;
            res.changed = 1'b1;
          end
        end
      end
      CMD_SET_LEVEL: begin
        if (level[LEVEL_BITS-1]) begin
          duty = '0;
        end else if (level > LEVEL_BITS'(FULL_SCALE)) begin
          duty = FULL_SCALE;
        end else begin
          duty = level[DUTY_BITS-1:0];
        end
      end
      CMD_FORCE_OFF: begin
        res.changed = relay_q;
        duty = '0;
        relay_q = 1'b0;
        last_switch = tick_count;
      end
      default: ;
    endcase
    res.relay_on = relay_q;
    return res;
  endfunction

  always @(posedge clk) begin
    relay_result_t exp_res;
    if (!rst_n) begin
      window_len = WINDOW_RESET;
      min_on_len = '0;
      min_off_len = '0;
      win_pos = '0;
      duty = '0;
      relay_q = 1'b0;
      tick_count = '0;
      last_switch = '0;
      expected_relay_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_WINDOW:  window_len = cfg_wdata;
          REG_MIN_ON:  min_on_len = cfg_wdata;
          REG_MIN_OFF: min_off_len = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_relay_q.size() == 0) begin
          $display("%0t unexpected result: relay_on %0b relay_changed %0b",
                   $time, out_relay_on, out_relay_changed);
          mismatches++;
        end else begin
          exp_res = expected_relay_q.pop_front();
          if (out_relay_on !== exp_res.relay_on) begin
            $display("%0t relay_on mismatch: expected %0b actual %0b",
                     $time, exp_res.relay_on, out_relay_on);
            mismatches++;
          end
          if (out_relay_changed !== exp_res.changed) begin
            $display("%0t relay_changed mismatch: expected %0b actual %0b",
                     $time, exp_res.changed, out_relay_changed);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_relay_q.push_back(apply_command(in_cmd, in_level));
      end
    end
    fail_total <= mismatches;
    pending <= expected_relay_q.size();
  end

endmodule

[tb/time_proportioning_relay_test.sv]
`timescale 1ns / 1ps
module time_proportioning_relay_test;
  import trp_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
  localparam logic [REG_BITS-1:0] REG_MAX = {REG_BITS{1'b1}};

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [REG_BITS-1:0] cfg_wdata;
  int send_gap_pct = 0;
  int stall_pct = 0;
  int fail_total;
  int pending;
  int cycle_count = 0;

  trp_in_if  in_ch ();
  trp_out_if out_ch ();

  always #(HALF_PERIOD) clk = ~clk;

  time_proportioning_relay u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  relay_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .in_cmd            (in_ch.cmd),
    .in_level          (in_ch.level),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_relay_on      (out_ch.relay_on),
    .out_relay_changed (out_ch.relay_changed),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .fail_total        (fail_total),
    .pending           (pending)
  );

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // ready is settled by the falling edge, so it tells whether the next rising edge accepts
  task automatic send_item(input logic [CMD_BITS-1:0] cmd, input logic [LEVEL_BITS-1:0] level);
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.level <= level;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [REG_BITS-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic configure(input logic [REG_BITS-1:0] window, input logic [REG_BITS-1:0] min_on,
                           input logic [REG_BITS-1:0] min_off);
    write_reg(REG_WINDOW, window);
    write_reg(REG_MIN_ON, min_on);
    write_reg(REG_MIN_OFF, min_off);
    cfg_we <= 1'b0;
  endtask

  task automatic set_idle(input idle_mode_t mode);
    send_gap_pct = (mode == IDLE_SENDER) ? 72 : (mode == IDLE_BOTH) ? 17 : 0;
    stall_pct = (mode == IDLE_RECEIVER) ? 72 : (mode == IDLE_BOTH) ? 17 : 0;
  endtask

  // mostly ticks with level updates mixed in, some force-offs and unused commands
  task automatic send_random(input int count);
    int done;
    int pick;
    logic [LEVEL_BITS-1:0] lvl;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(99);
      if (pick < 68) begin
        send_item(CMD_TICK, LEVEL_BITS'($urandom));
        done++;
      end else if (pick < 88) begin
        case ($urandom_range(9))
          0: lvl = LEVEL_BITS'(FULL_SCALE);
          1: lvl = '0;
          2, 3: lvl = LEVEL_BITS'($urandom);
          default: lvl = LEVEL_BITS'($urandom_range(FULL_SCALE));
        endcase
        send_item(CMD_SET_LEVEL, lvl);
        done++;
      end else if (pick < 94) begin
        send_item(CMD_FORCE_OFF, LEVEL_BITS'($urandom));
        done++;
      end else begin
        send_item(CMD_UNUSED, LEVEL_BITS'($urandom));
      end
    end
  endtask

  task automatic run_phase(input logic [REG_BITS-1:0] window, input logic [REG_BITS-1:0] min_on,
                           input logic [REG_BITS-1:0] min_off, input idle_mode_t mode,
                           input int count);
    settle();
    configure(window, min_on, min_off);
    set_idle(mode);
    send_random(count);
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_WINDOW;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.cmd <= CMD_TICK;
    in_ch.level <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: level clamping, force off, unused command
    send_item(CMD_UNUSED, 16'h7fff);
    send_item(CMD_TICK, '0);
    send_item(CMD_SET_LEVEL, 16'h8000);
    send_item(CMD_SET_LEVEL, 16'h7fff);
    send_item(CMD_TICK, '0);
    send_item(CMD_TICK, 16'hffff);
    send_item(CMD_FORCE_OFF, '0);
    send_item(CMD_FORCE_OFF, 16'hffff);
    send_item(CMD_SET_LEVEL, LEVEL_BITS'(FULL_SCALE) + 1'b1);
    send_item(CMD_TICK, '0);
    send_item(CMD_SET_LEVEL, '0);
    send_item(CMD_TICK, '0);
    send_item(CMD_SET_LEVEL, 16'hffff);
    send_item(CMD_SET_LEVEL, 16'h0001);
    send_item(CMD_TICK, '0);
    send_item(CMD_UNUSED, 16'hffff);

    // window shrunk below the current position wraps on the next tick
    settle();
    configure(20'd2, 20'd0, 20'd0);
    send_item(CMD_SET_LEVEL, LEVEL_BITS'(FULL_SCALE / 2));
    send_item(CMD_TICK, '0);
    send_item(CMD_TICK, '0);
    send_item(CMD_TICK, '0);
    send_item(CMD_SET_LEVEL, LEVEL_BITS'(FULL_SCALE));
    send_item(CMD_TICK, '0);

    run_phase(20'd16, 20'd0, 20'd0, IDLE_NONE, 70);
    run_phase(20'd25, 20'd3, 20'd2, IDLE_SENDER, 70);
    run_phase(20'd10, REG_MAX, 20'd0, IDLE_RECEIVER, 60);
    run_phase(20'd12, 20'd0, REG_MAX, IDLE_BOTH, 60);
    run_phase(20'd0, 20'd5, 20'd5, IDLE_NONE, 60);
    run_phase(REG_MAX, 20'd0, 20'd0, IDLE_SENDER, 50);
    run_phase(20'd1, 20'd0, 20'd0, IDLE_RECEIVER, 50);
    run_phase(20'd33, 20'd7, 20'd4, IDLE_BOTH, 70);
    run_phase(20'd7, 20'd1, 20'd0, IDLE_NONE, 50);

    settle();
    repeat (8) @(posedge clk);
    if (fail_total == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
